/* hdl/tmdr_pkg.sv */
// Shared codes, command and status types for the tile map renderer.
`timescale 1ns / 1ps
package tmdr_pkg;

	localparam int DESC_W = 48;

	localparam logic OP_SET  = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	localparam logic [1:0] KIND_SET   = 2'd0;
	localparam logic [1:0] KIND_DRAW  = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OOB  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
	localparam logic [2:0] REG_TILE_SIZE   = 3'd2;
	localparam logic [2:0] REG_MAP_COLUMNS = 3'd3;
	localparam logic [2:0] REG_MAP_ROWS    = 3'd4;

	typedef struct packed {
		logic       capture;
		logic       srch_clear;
		logic       srch_run;
		logic       set_commit;
		logic       emit_set;
		logic [1:0] set_status;
		logic       draw_start;
		logic       draw_run;
		logic       draw_finish;
	} dp_cmd_t;

	typedef struct packed {
		logic oob;
		logic hit;
		logic miss;
		logic full;
		logic drain_done;
	} dp_stat_t;

endpackage

/* hdl/tmdr_ram.sv */
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
module tmdr_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/tmdr_ctrl.sv */
// Controller state machine sequencing set and draw items.
`timescale 1ns / 1ps
module tmdr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              operation,
	input  tmdr_pkg::dp_stat_t stat,
	output tmdr_pkg::dp_cmd_t  cmd,
	output logic              busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SEARCH,
		S_WRITE,
		S_DRAW
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	assign busy = busy_q;

	always_comb begin
		cmd = '0;
		cmd.set_status = tmdr_pkg::ST_OK;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					if (operation == tmdr_pkg::OP_DRAW) begin
						cmd.draw_start = 1'b1;
						state_d = S_DRAW;
					end else begin
						state_d = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				if (stat.oob) begin
					cmd.emit_set = 1'b1;
					cmd.set_status = tmdr_pkg::ST_OOB;
					state_d = S_IDLE;
				end else begin
					cmd.srch_clear = 1'b1;
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				cmd.srch_run = 1'b1;
				if (stat.hit) begin
					state_d = S_WRITE;
				end else if (stat.miss) begin
					if (stat.full) begin
						cmd.emit_set = 1'b1;
						cmd.set_status = tmdr_pkg::ST_FULL;
						state_d = S_IDLE;
					end else begin
						state_d = S_WRITE;
					end
				end
			end
			S_WRITE: begin
				cmd.set_commit = 1'b1;
				cmd.emit_set = 1'b1;
				state_d = S_IDLE;
			end
			S_DRAW: begin
				if (stat.drain_done) begin
					cmd.draw_finish = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.draw_run = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q <= (state_d != S_IDLE);
		end
	end

endmodule

/* hdl/tmdr_datapath.sv */
// Datapath: config registers, tile grid, descriptor table, search and draw pipes.
`timescale 1ns / 1ps
module tmdr_datapath #(
	parameter int MAX_COLUMNS = 8,
	parameter int MAX_ROWS    = 8,
	parameter int TABLE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic signed [7:0]  column,
	input  logic signed [7:0]  grid_row,
	input  logic [15:0]        texture_ref,
	input  logic [15:0]        src_x,
	input  logic [15:0]        src_y,
	input  tmdr_pkg::dp_cmd_t  cmd,
	output tmdr_pkg::dp_stat_t stat,
	output logic               result_strobe,
	output logic [1:0]         result_kind,
	output logic [1:0]         status,
	output logic [3:0]         tile_id,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic [15:0]        out_texture,
	output logic [15:0]        out_src_x,
	output logic [15:0]        out_src_y,
	output logic               last
);

	localparam int GRID_DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int GA_W       = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
	localparam int ID_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
	localparam int COLS_CAP   = (MAX_COLUMNS > 15) ? 15 : MAX_COLUMNS;
	localparam int ROWS_CAP   = (MAX_ROWS > 15) ? 15 : MAX_ROWS;
	localparam int DW         = tmdr_pkg::DESC_W;

	// configuration
	logic [15:0] origin_x_q;
	logic [15:0] origin_y_q;
	logic [7:0]  tile_size_q;
	logic [3:0]  map_columns_q;
	logic [3:0]  map_rows_q;
	logic [3:0]  cols_used;
	logic [3:0]  rows_used;

	// latched set item
	logic [7:0]    col_q;
	logic [7:0]    row_q;
	logic [DW-1:0] key_q;
	logic [7:0]    set_lin;
	logic [GA_W-1:0] set_addr_q;

	// table state
	logic [CNT_W-1:0] count_q;
	logic [GRID_DEPTH-1:0] gvld_q;
	logic [ID_W-1:0]  chosen_q;
	logic             append_q;

	// search pipe
	logic [CNT_W-1:0] srch_idx_q;
	logic [CNT_W-1:0] srch_idx_s1;
	logic             srch_run_s1;
	logic             srch_vld_s1;
	logic             srch_eq;
	logic             hit;
	logic             miss;

	// draw pipe
	logic             scan_on_q;
	logic [GA_W-1:0]  scan_a_q;
	logic [3:0]       scan_c_q;
	logic [3:0]       scan_r_q;
	logic             vld_s1;
	logic             gvld_s1;
	logic [3:0]       c_s1;
	logic [3:0]       r_s1;
	logic [ID_W-1:0]  cell_id;
	logic             cell_draw;
	logic [11:0]      prod_x;
	logic [11:0]      prod_y;
	logic             draw_s2;
	logic [ID_W-1:0]  id_s2;
	logic [16:0]      px_s2;
	logic [16:0]      py_s2;
	logic             pend_vld_q;
	logic [ID_W-1:0]  pend_id_q;
	logic [16:0]      pend_px_q;
	logic [16:0]      pend_py_q;
	logic [DW-1:0]    pend_desc_q;

	// memories
	logic [ID_W-1:0]  grid_rd;
	logic [DW-1:0]    desc_rd;
	logic [ID_W-1:0]  desc_raddr;

	// result select
	logic             e_vld;
	logic [1:0]       e_kind;
	logic [1:0]       e_status;
	logic [3:0]       e_id;
	logic [16:0]      e_px;
	logic [16:0]      e_py;
	logic [DW-1:0]    e_desc;
	logic             e_last;

	assign cols_used = (int'(map_columns_q) > COLS_CAP) ? 4'(COLS_CAP) : map_columns_q;
	assign rows_used = (int'(map_rows_q) > ROWS_CAP) ? 4'(ROWS_CAP) : map_rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			tile_size_q <= 8'd16;
			map_columns_q <= 4'd8;
			map_rows_q <= 4'd8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tmdr_pkg::REG_ORIGIN_X:    origin_x_q <= cfg_data;
				tmdr_pkg::REG_ORIGIN_Y:    origin_y_q <= cfg_data;
				tmdr_pkg::REG_TILE_SIZE:   tile_size_q <= cfg_data[7:0];
				tmdr_pkg::REG_MAP_COLUMNS: map_columns_q <= cfg_data[3:0];
				tmdr_pkg::REG_MAP_ROWS:    map_rows_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// set: bounds and cell address
	assign set_lin = row_q[3:0] * cols_used + {4'd0, col_q[3:0]};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			col_q <= column;
			row_q <= grid_row;
			key_q <= {src_y, src_x, texture_ref};
		end
		set_addr_q <= GA_W'(set_lin);
	end

	assign stat.oob = col_q[7] | row_q[7] | (col_q >= {4'd0, cols_used}) |
		(row_q >= {4'd0, rows_used});

	// search: one descriptor per cycle, compared in the cycle after its read
	assign srch_eq = (srch_idx_s1 == '0) ? (key_q == '0) : (desc_rd == key_q);
	assign hit = cmd.srch_run & srch_run_s1 & srch_vld_s1 & srch_eq;
	assign miss = cmd.srch_run & srch_run_s1 & ~srch_vld_s1;
	assign stat.hit = hit;
	assign stat.miss = miss;
	assign stat.full = (count_q == CNT_W'(TABLE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srch_run_s1 <= 1'b0;
			srch_vld_s1 <= 1'b0;
			srch_idx_q <= '0;
			srch_idx_s1 <= '0;
		end else if (cmd.srch_clear) begin
			srch_run_s1 <= 1'b0;
			srch_vld_s1 <= 1'b0;
			srch_idx_q <= '0;
		end else begin
			srch_run_s1 <= cmd.srch_run;
			srch_vld_s1 <= cmd.srch_run & (srch_idx_q < count_q);
			srch_idx_s1 <= srch_idx_q;
			if (cmd.srch_run) begin
				srch_idx_q <= srch_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit | miss) begin
			chosen_q <= hit ? srch_idx_s1[ID_W-1:0] : count_q[ID_W-1:0];
			append_q <= ~hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1);
			gvld_q <= '0;
		end else if (cmd.set_commit) begin
			gvld_q[set_addr_q] <= 1'b1;
			if (append_q) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// draw: scan grid, look up descriptor, hold one command back to mark the last
	assign cell_id = gvld_s1 ? grid_rd : '0;
	assign cell_draw = vld_s1 & (cell_id != '0) & (CNT_W'(cell_id) < count_q);
	assign desc_raddr = cmd.draw_run ? cell_id : srch_idx_q[ID_W-1:0];
	assign prod_x = c_s1 * tile_size_q;
	assign prod_y = r_s1 * tile_size_q;
	assign stat.drain_done = ~scan_on_q & ~vld_s1 & ~draw_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_on_q <= 1'b0;
			vld_s1 <= 1'b0;
			draw_s2 <= 1'b0;
			pend_vld_q <= 1'b0;
		end else if (cmd.draw_start) begin
			scan_on_q <= (cols_used != 4'd0) & (rows_used != 4'd0);
			vld_s1 <= 1'b0;
			draw_s2 <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.draw_run & scan_on_q;
			draw_s2 <= cmd.draw_run & cell_draw;
			if (cmd.draw_run & scan_on_q & (scan_c_q == cols_used - 4'd1) &
				(scan_r_q == rows_used - 4'd1)) begin
				scan_on_q <= 1'b0;
			end
			if (cmd.draw_run & draw_s2) begin
				pend_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.draw_start) begin
			scan_a_q <= '0;
			scan_c_q <= '0;
			scan_r_q <= '0;
		end else if (cmd.draw_run & scan_on_q) begin
			scan_a_q <= scan_a_q + 1'b1;
			if (scan_c_q == cols_used - 4'd1) begin
				scan_c_q <= '0;
				scan_r_q <= scan_r_q + 4'd1;
			end else begin
				scan_c_q <= scan_c_q + 4'd1;
			end
		end
		gvld_s1 <= gvld_q[scan_a_q];
		c_s1 <= scan_c_q;
		r_s1 <= scan_r_q;
		id_s2 <= cell_id;
		px_s2 <= {origin_x_q[15], origin_x_q} + 17'(prod_x);
		py_s2 <= {origin_y_q[15], origin_y_q} + 17'(prod_y);
		if (cmd.draw_run & draw_s2) begin
			pend_id_q <= id_s2;
			pend_px_q <= px_s2;
			pend_py_q <= py_s2;
			pend_desc_q <= desc_rd;
		end
	end

	tmdr_ram #(
		.WIDTH (ID_W),
		.DEPTH (GRID_DEPTH),
		.ADDR_W(GA_W)
	) u_grid_ram (
		.clk  (clk),
		.we   (cmd.set_commit),
		.waddr(set_addr_q),
		.wdata(chosen_q),
		.raddr(scan_a_q),
		.rdata(grid_rd)
	);

	tmdr_ram #(
		.WIDTH (DW),
		.DEPTH (TABLE_DEPTH),
		.ADDR_W(ID_W)
	) u_desc_ram (
		.clk  (clk),
		.we   (cmd.set_commit & append_q),
		.waddr(count_q[ID_W-1:0]),
		.wdata(key_q),
		.raddr(desc_raddr),
		.rdata(desc_rd)
	);

	// result register
	always_comb begin
		e_vld = 1'b0;
		e_kind = tmdr_pkg::KIND_SET;
		e_status = tmdr_pkg::ST_OK;
		e_id = '0;
		e_px = '0;
		e_py = '0;
		e_desc = '0;
		e_last = 1'b0;
		priority if (cmd.emit_set) begin
			e_vld = 1'b1;
			e_status = cmd.set_status;
			e_id = (cmd.set_status == tmdr_pkg::ST_OK) ? 4'(chosen_q) : 4'd0;
			e_last = 1'b1;
		end else if (cmd.draw_run & draw_s2 & pend_vld_q) begin
			e_vld = 1'b1;
			e_kind = tmdr_pkg::KIND_DRAW;
			e_id = 4'(pend_id_q);
			e_px = pend_px_q;
			e_py = pend_py_q;
			e_desc = pend_desc_q;
		end else if (cmd.draw_finish) begin
			e_vld = 1'b1;
			e_last = 1'b1;
			if (pend_vld_q) begin
				e_kind = tmdr_pkg::KIND_DRAW;
				e_id = 4'(pend_id_q);
				e_px = pend_px_q;
				e_py = pend_py_q;
				e_desc = pend_desc_q;
			end else begin
				e_kind = tmdr_pkg::KIND_EMPTY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= e_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (e_vld) begin
			result_kind <= e_kind;
			status <= e_status;
			tile_id <= e_id;
			pos_x <= e_px;
			pos_y <= e_py;
			out_texture <= e_desc[15:0];
			out_src_x <= e_desc[31:16];
			out_src_y <= e_desc[47:32];
			last <= e_last;
		end
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(1)) && (count_q <= CNT_W'(TABLE_DEPTH)))
		else $error("descriptor count out of range");

	a_no_append_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_commit && append_q |-> count_q < CNT_W'(TABLE_DEPTH))
		else $error("append into full table");

	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.draw_finish |=> result_strobe && last)
		else $error("draw end without final item");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result_kind == tmdr_pkg::KIND_EMPTY |-> last && !$past(pend_vld_q))
		else $error("empty marker with pending command");

	a_fail_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result_kind == tmdr_pkg::KIND_SET && status != tmdr_pkg::ST_OK
		|-> tile_id == 4'd0)
		else $error("failed set with nonzero id");
`endif

endmodule

/* hdl/tile_map_dedup_renderer.sv */
// Top level of the tile map renderer with deduplicating descriptor table.
`timescale 1ns / 1ps
// An item is taken when start is high and busy is low; results appear one per
// cycle-long result_strobe pulse and cannot be held off. A set item is bound by
// the descriptor search that reads one table entry per cycle; an out-of-bounds
// set ends without a search. A draw item scans the grid, one grid cell read per
// cycle, with commands spread through that scan. Draw commands are held back by
// one so the final one carries last. Config writes are not blocked while busy;
// write them only while busy is low and no result is due.
module tile_map_dedup_renderer #(
	parameter int MAX_COLUMNS = 8,
	parameter int MAX_ROWS    = 8,
	parameter int TABLE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic signed [7:0]  column,
	input  logic signed [7:0]  grid_row,
	input  logic [15:0]        texture_ref,
	input  logic [15:0]        src_x,
	input  logic [15:0]        src_y,
	output logic               result_strobe,
	output logic [1:0]         result_kind,
	output logic [1:0]         status,
	output logic [3:0]         tile_id,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic [15:0]        out_texture,
	output logic [15:0]        out_src_x,
	output logic [15:0]        out_src_y,
	output logic               last
);

	tmdr_pkg::dp_cmd_t  cmd;
	tmdr_pkg::dp_stat_t stat;

	tmdr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.operation(operation),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	tmdr_datapath #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS),
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.column       (column),
		.grid_row     (grid_row),
		.texture_ref  (texture_ref),
		.src_x        (src_x),
		.src_y        (src_y),
		.cmd          (cmd),
		.stat         (stat),
		.result_strobe(result_strobe),
		.result_kind  (result_kind),
		.status       (status),
		.tile_id      (tile_id),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.out_texture  (out_texture),
		.out_src_x    (out_src_x),
		.out_src_y    (out_src_y),
		.last         (last)
	);

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the tile map renderer: directed cases, then random sweeps.
`timescale 1ns / 1ps
module testbench;

	localparam int MAX_COLS       = 8;
	localparam int MAX_ROWS_USED  = 8;
	localparam int TABLE_DEPTH    = 16;
	localparam int POOL_SIZE      = TABLE_DEPTH - 1;
	localparam int SEGMENT_ITEMS  = 45;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TAIL_CYCLES    = 80;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  st;
		logic [3:0]  id;
		logic [16:0] px;
		logic [16:0] py;
		logic [15:0] tex;
		logic [15:0] sx;
		logic [15:0] sy;
		logic        last;
	} render_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               start;
	logic               busy;
	logic               operation;
	logic signed [7:0]  column;
	logic signed [7:0]  grid_row;
	logic [15:0]        texture_ref;
	logic [15:0]        src_x;
	logic [15:0]        src_y;
	logic               result_strobe;
	logic [1:0]         result_kind;
	logic [1:0]         status;
	logic [3:0]         tile_id;
	logic signed [16:0] pos_x;
	logic signed [16:0] pos_y;
	logic [15:0]        out_texture;
	logic [15:0]        out_src_x;
	logic [15:0]        out_src_y;
	logic               last;

	// predictor state
	logic [3:0]         tile_grid_m [MAX_COLS * MAX_ROWS_USED];
	logic [47:0]        desc_store [TABLE_DEPTH];
	int                 desc_used;
	logic signed [15:0] org_x_m;
	logic signed [15:0] org_y_m;
	logic [7:0]         tile_size_m;
	logic [3:0]         map_cols_m;
	logic [3:0]         map_rows_m;

	logic [47:0]        desc_pool [POOL_SIZE];
	render_t            pending_results [$];
	render_t            head;
	int                 fail_count;
	int                 items_sent;
	int                 draws_sent;
	int                 results_checked;
	int                 quiet_cycles;
	int                 settings_applied;

	tile_map_dedup_renderer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.column       (column),
		.grid_row     (grid_row),
		.texture_ref  (texture_ref),
		.src_x        (src_x),
		.src_y        (src_y),
		.result_strobe(result_strobe),
		.result_kind  (result_kind),
		.status       (status),
		.tile_id      (tile_id),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.out_texture  (out_texture),
		.out_src_x    (out_src_x),
		.out_src_y    (out_src_y),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic predict_render(input logic op, input logic signed [7:0] col,
			input logic signed [7:0] row, input logic [47:0] desc);
		int cols;
		int rows;
		int ci;
		int ri;
		int id;
		int i;
		bit hit;
		render_t res;
		render_t cmds [$];
		cols = (map_cols_m > MAX_COLS) ? MAX_COLS : int'(map_cols_m);
		rows = (map_rows_m > MAX_ROWS_USED) ? MAX_ROWS_USED : int'(map_rows_m);
		res = '0;
		if (op == tmdr_pkg::OP_SET) begin
			res.kind = tmdr_pkg::KIND_SET;
			res.last = 1'b1;
			ci = col;
			ri = row;
			if (ci < 0 || ri < 0 || ci >= cols || ri >= rows) begin
				res.st = tmdr_pkg::ST_OOB;
			end else begin
				hit = 1'b0;
				id = 0;
				for (i = 0; i < desc_used; i++) begin
					if (!hit && desc_store[i] == desc) begin
						hit = 1'b1;
						id = i;
					end
				end
				if (!hit && desc_used >= TABLE_DEPTH) begin
					res.st = tmdr_pkg::ST_FULL;
				end else begin
					if (!hit) begin
						id = desc_used;
						desc_store[id] = desc;
						desc_used++;
					end
					tile_grid_m[ri * cols + ci] = 4'(id);
					res.st = tmdr_pkg::ST_OK;
					res.id = 4'(id);
				end
			end
			pending_results.push_back(res);
		end else begin
			for (ri = 0; ri < rows; ri++) begin
				for (ci = 0; ci < cols; ci++) begin
					id = int'(tile_grid_m[ri * cols + ci]);
					if (id > 0 && id < desc_used) begin
						res = '0;
						res.kind = tmdr_pkg::KIND_DRAW;
						res.st = tmdr_pkg::ST_OK;
						res.id = 4'(id);
						res.px = 17'(int'(org_x_m) + ci * int'(tile_size_m));
						res.py = 17'(int'(org_y_m) + ri * int'(tile_size_m));
						res.tex = desc_store[id][15:0];
						res.sx = desc_store[id][31:16];
						res.sy = desc_store[id][47:32];
						cmds.push_back(res);
					end
				end
			end
			if (cmds.size() == 0) begin
				res = '0;
				res.kind = tmdr_pkg::KIND_EMPTY;
				res.last = 1'b1;
				pending_results.push_back(res);
			end else begin
				cmds[cmds.size() - 1].last = 1'b1;
				foreach (cmds[k]) pending_results.push_back(cmds[k]);
			end
		end
	endtask

	function automatic void check_field(input string name, input logic [16:0] want,
			input logic [16:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_strobe === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: kind %0d id %0d", result_kind, tile_id);
				fail_count++;
			end else begin
				head = pending_results.pop_front();
				results_checked++;
				check_field("result_kind", 17'(head.kind), 17'(result_kind));
				check_field("status", 17'(head.st), 17'(status));
				check_field("tile_id", 17'(head.id), 17'(tile_id));
				check_field("pos_x", head.px, pos_x);
				check_field("pos_y", head.py, pos_y);
				check_field("out_texture", 17'(head.tex), 17'(out_texture));
				check_field("out_src_x", 17'(head.sx), 17'(out_src_x));
				check_field("out_src_y", 17'(head.sy), 17'(out_src_y));
				check_field("last", 17'(head.last), 17'(last));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_strobe === 1'b1 || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	task automatic send_item(input logic op, input logic [7:0] col, input logic [7:0] row,
			input logic [47:0] desc);
		@(negedge clk);
		start       <= 1'b1;
		operation   <= op;
		column      <= col;
		grid_row    <= row;
		texture_ref <= desc[15:0];
		src_x       <= desc[31:16];
		src_y       <= desc[47:32];
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_render(op, col, row, desc);
		items_sent++;
		if (op == tmdr_pkg::OP_DRAW) draws_sent++;
	endtask

	task automatic send_set(input int col, input int row, input logic [47:0] desc);
		send_item(tmdr_pkg::OP_SET, col[7:0], row[7:0], desc);
	endtask

	task automatic send_draw();
		send_item(tmdr_pkg::OP_DRAW, 8'($urandom), 8'($urandom),
			{16'($urandom), 32'($urandom)});
	endtask

	task automatic sender_gap(input int pct);
		int n;
		n = 0;
		while ($urandom_range(99) < pct && n < 60) begin
			@(negedge clk);
			start <= 1'b0;
			n++;
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0 || busy) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		unique case (idx)
			tmdr_pkg::REG_ORIGIN_X:    org_x_m = val;
			tmdr_pkg::REG_ORIGIN_Y:    org_y_m = val;
			tmdr_pkg::REG_TILE_SIZE:   tile_size_m = val[7:0];
			tmdr_pkg::REG_MAP_COLUMNS: map_cols_m = val[3:0];
			tmdr_pkg::REG_MAP_ROWS:    map_rows_m = val[3:0];
			default: ;
		endcase
	endtask

	task automatic apply_config(input logic [15:0] ox, input logic [15:0] oy,
			input logic [7:0] ts, input logic [3:0] nc, input logic [3:0] nr);
		wait_idle();
		write_reg(tmdr_pkg::REG_ORIGIN_X, ox);
		write_reg(tmdr_pkg::REG_ORIGIN_Y, oy);
		write_reg(tmdr_pkg::REG_TILE_SIZE, {8'd0, ts});
		write_reg(tmdr_pkg::REG_MAP_COLUMNS, {12'd0, nc});
		write_reg(tmdr_pkg::REG_MAP_ROWS, {12'd0, nr});
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	task automatic build_pool();
		int i;
		int j;
		bit dup;
		desc_pool[0] = 48'hFFFF_FFFF_FFFF;
		desc_pool[1] = 48'h0000_0000_0001;
		for (i = 2; i < POOL_SIZE; i++) begin
			do begin
				desc_pool[i] = {16'($urandom), 32'($urandom)};
				dup = (desc_pool[i] == '0);
				for (j = 0; j < i; j++) if (desc_pool[j] == desc_pool[i]) dup = 1'b1;
			end while (dup);
		end
	endtask

	// fresh map draws nothing; an all-zero descriptor resolves to the empty id
	task automatic test_empty_map();
		send_draw();
		send_set(0, 0, '0);
		send_draw();
	endtask

	task automatic test_bounds();
		send_set(-1, 0, desc_pool[0]);
		send_set(MAX_COLS, 0, desc_pool[0]);
		send_set(0, MAX_ROWS_USED, desc_pool[0]);
		send_set(127, -128, desc_pool[0]);
		send_set(MAX_COLS - 1, MAX_ROWS_USED - 1, desc_pool[0]);
	endtask

	task automatic test_dedup();
		send_set(3, 2, desc_pool[0]);
		send_set(0, 0, desc_pool[1]);
	endtask

	task automatic test_table_full();
		int i;
		for (i = 2; i < POOL_SIZE; i++) send_set(i % MAX_COLS, i / MAX_COLS + 1, desc_pool[i]);
		send_set(4, 4, 48'h8000_8000_8000);
		send_set(5, 5, desc_pool[5]);
	endtask

	task automatic test_draw_full();
		send_draw();
	endtask

	task automatic run_random_segment(input int n_items, input int idle_pct);
		int k;
		int pick;
		logic [47:0] d;
		logic [7:0] c;
		logic [7:0] r;
		for (k = 0; k < n_items; k++) begin
			sender_gap(idle_pct);
			if ($urandom_range(99) < 4) wait_idle();
			if ($urandom_range(99) < 20) begin
				send_draw();
			end else begin
				pick = $urandom_range(99);
				if (pick < 10)
					d = '0;
				else if (pick < 80)
					d = desc_pool[$urandom_range(POOL_SIZE - 1)];
				else
					d = {16'($urandom), 32'($urandom)};
				if ($urandom_range(99) < 75) begin
					c = 8'($urandom_range(MAX_COLS - 1));
					r = 8'($urandom_range(MAX_ROWS_USED - 1));
				end else begin
					c = 8'($urandom);
					r = 8'($urandom);
				end
				send_item(tmdr_pkg::OP_SET, c, r, d);
			end
		end
	endtask

	// register extremes first, oversized and zero grid shapes, then random settings
	task automatic test_register_sweep();
		int seg;
		int idle_pct [4] = '{0, 82, 0, 15};
		for (seg = 0; seg < 8; seg++) begin
			unique case (seg)
				0: apply_config(16'h8000, 16'h7FFF, 8'd255, 4'd15, 4'd15);
				1: apply_config(16'h7FFF, 16'h8000, 8'd0, 4'd3, 4'd5);
				2: apply_config(16'h0000, 16'h0000, 8'd1, 4'd0, 4'd8);
				3: apply_config(16'hFFFF, 16'h0001, 8'd16, 4'd8, 4'd0);
				4: apply_config(16'h1234, 16'hFEDC, 8'd7, 4'd1, 4'd8);
				default: apply_config(16'($urandom), 16'($urandom), 8'($urandom),
					4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)));
			endcase
			run_random_segment(SEGMENT_ITEMS, idle_pct[seg % 4]);
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		start       = 1'b0;
		operation   = tmdr_pkg::OP_SET;
		column      = '0;
		grid_row    = '0;
		texture_ref = '0;
		src_x       = '0;
		src_y       = '0;
		fail_count = 0;
		items_sent = 0;
		draws_sent = 0;
		results_checked = 0;
		settings_applied = 0;
		foreach (tile_grid_m[i]) tile_grid_m[i] = '0;
		foreach (desc_store[i]) desc_store[i] = '0;
		desc_used   = 1;
		org_x_m     = '0;
		org_y_m     = '0;
		tile_size_m = 8'd16;
		map_cols_m  = 4'd8;
		map_rows_m  = 4'd8;
		build_pool();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_map();
		test_bounds();
		test_dedup();
		test_table_full();
		test_draw_full();
		test_register_sweep();

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d items (%0d draws), %0d results checked, %0d register settings",
			items_sent, draws_sent, results_checked, settings_applied);
		$display("covered bounds, dedup, full table, empty draws, grid reshaping and idling");
		if (fail_count == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
